// ===== design/dbfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dbfp_pkg
// Types, codes and the type letter table shared by the table stream parser.
// ----------------------------------------------------------------------------
`default_nettype none
package dbfp_pkg;

	localparam int MAX_FIELDS_DEF = 256;

	localparam logic [2:0] KIND_HDR_DONE = 3'd0;
	localparam logic [2:0] KIND_REC_START = 3'd1;
	localparam logic [2:0] KIND_FLD_BYTE = 3'd2;
	localparam logic [2:0] KIND_EXT_REF = 3'd3;
	localparam logic [2:0] KIND_END = 3'd4;
	localparam logic [2:0] KIND_ERROR = 3'd5;

	localparam logic [1:0] ERR_DEL_FLAG = 2'd0;
	localparam logic [1:0] ERR_TYPE = 2'd1;
	localparam logic [1:0] ERR_HEADER = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	localparam logic [7:0] FLAG_LIVE = 8'h20;
	localparam logic [7:0] FLAG_DELETED = 8'h2A;
	localparam logic [3:0] TYPE_CHAR = 4'd0;
	localparam logic [3:0] TYPE_BAD = 4'd12;
	localparam logic [7:0] EXT_REF_LEN = 8'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] record_index;
		logic [7:0]  field_index;
		logic [3:0]  field_type;
		logic [7:0]  field_byte;
		logic        last_of_field;
		logic        deleted;
		logic [31:0] ext_offset;
		logic [15:0] ext_length;
		logic [1:0]  error_code;
		logic [23:0] date_stamp;
		logic [8:0]  field_count;
	} res_t;

	function automatic logic [3:0] type_code(input logic [7:0] b);
		logic [3:0] c;
		case (b)
			8'h43: c = 4'd0;  // C
			8'h59: c = 4'd1;  // Y
			8'h4E: c = 4'd2;  // N
			8'h46: c = 4'd3;  // F
			8'h44: c = 4'd4;  // D
			8'h54: c = 4'd5;  // T
			8'h42: c = 4'd6;  // B
			8'h49: c = 4'd7;  // I
			8'h4C: c = 4'd8;  // L
			8'h4D: c = 4'd9;  // M
			8'h47: c = 4'd10; // G
			8'h50: c = 4'd11; // P
			default: c = TYPE_BAD;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/dbfp_parser.sv =====
// ----------------------------------------------------------------------------
// dbfp_parser
// Byte-level parse state: header, descriptor table, records. Gives up to two
// results per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none
module dbfp_parser #(
	parameter int MAX_FIELDS = dbfp_pkg::MAX_FIELDS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            acc,
	input  wire logic [7:0]      data_byte,
	input  wire logic            end_of_input,
	output dbfp_pkg::res_t       res0,
	output dbfp_pkg::res_t       res1,
	output logic [1:0]           res_n
);

	localparam int IW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int CW = $clog2(MAX_FIELDS + 1);
	localparam int DEPTH = 1 << IW;
	localparam logic [CW-1:0] MAXF = CW'(MAX_FIELDS);

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_FLAG   = 5'b00010,
		PH_FIELD  = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_ERROR  = 5'b10000
	} phase_t;

	// one stored descriptor of nonzero length
	typedef struct packed {
		logic [IW-1:0] idx;
		logic [3:0]    ftype;
		logic [7:0]    flen;
	} ent_t;

	ent_t mem [DEPTH];

	phase_t        phase_q, phase_n;
	logic [15:0]   pos_q, pos_n;
	logic [31:0]   total_q, total_n;
	logic [15:0]   hlen_q, hlen_n;
	logic [23:0]   date_q, date_n;
	logic [CW-1:0] seen_q, seen_n;
	logic [CW-1:0] nz_q, nz_n;
	logic [31:0]   rec_q, rec_n;
	logic [IW-1:0] cf_q, cf_n;
	logic [IW-1:0] cpos_q, cpos_n;
	logic [7:0]    bif_q, bif_n;
	logic [47:0]   gath_q, gath_n;
	logic          del_q, del_n;
	logic [3:0]    dtype_q, dtype_n;
	logic [7:0]    dlen_q, dlen_n;
	ent_t          first_q, first_n;
	ent_t          cur_q, cur_n;
	ent_t          rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	ent_t          wr_ent;

	logic [4:0]    off;
	logic [3:0]    code;
	logic [47:0]   gnew;
	logic          adv;
	logic [CW-1:0] cnext;
	dbfp_pkg::res_t ra, rb;
	logic          va, vb;

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		total_n = total_q;
		hlen_n = hlen_q;
		date_n = date_q;
		seen_n = seen_q;
		nz_n = nz_q;
		rec_n = rec_q;
		cf_n = cf_q;
		cpos_n = cpos_q;
		bif_n = bif_q;
		gath_n = gath_q;
		del_n = del_q;
		dtype_n = dtype_q;
		dlen_n = dlen_q;
		first_n = first_q;
		cur_n = cur_q;
		rd_addr = IW'(cpos_q + 1'b1);
		wr_en = 1'b0;
		wr_ent = '{idx: IW'(seen_q), ftype: dtype_q, flen: dlen_q};
		off = pos_q[4:0];
		code = dbfp_pkg::type_code(data_byte);
		gnew = gath_q | (48'(data_byte) << {bif_q[2:0], 3'b000});
		adv = 1'b0;
		cnext = CW'(cpos_q) + 1'b1;
		ra = '0;
		rb = '0;
		va = 1'b0;
		vb = 1'b0;

		if (acc) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q >= 16'd1 && pos_q <= 16'd3)
						date_n = {date_q[15:0], data_byte};
					if (pos_q >= 16'd4 && pos_q <= 16'd7) begin
						case (pos_q[1:0])
							2'd0: total_n[7:0] = total_q[7:0] | data_byte;
							2'd1: total_n[15:8] = total_q[15:8] | data_byte;
							2'd2: total_n[23:16] = total_q[23:16] | data_byte;
							default: total_n[31:24] = total_q[31:24] | data_byte;
						endcase
					end
					if (pos_q == 16'd8)
						hlen_n[7:0] = hlen_q[7:0] | data_byte;
					if (pos_q == 16'd9)
						hlen_n[15:8] = hlen_q[15:8] | data_byte;
					if (pos_q == 16'd9 && hlen_n < 16'd12) begin
						va = 1'b1;
						ra.kind = dbfp_pkg::KIND_ERROR;
						ra.error_code = dbfp_pkg::ERR_HEADER;
					end else if (pos_q >= 16'd32 &&
						(17'({pos_q[15:5], 5'd0}) + 17'd32) <= 17'(hlen_q) &&
						off == 5'd0 && seen_q >= MAXF) begin
						va = 1'b1;
						ra.kind = dbfp_pkg::KIND_ERROR;
						ra.error_code = dbfp_pkg::ERR_HEADER;
					end else if (pos_q >= 16'd32 &&
						(17'({pos_q[15:5], 5'd0}) + 17'd32) <= 17'(hlen_q) &&
						off == 5'd11 && seen_q < MAXF && code == dbfp_pkg::TYPE_BAD) begin
						va = 1'b1;
						ra.kind = dbfp_pkg::KIND_ERROR;
						ra.error_code = dbfp_pkg::ERR_TYPE;
					end else begin
						if (pos_q >= 16'd32 &&
							(17'({pos_q[15:5], 5'd0}) + 17'd32) <= 17'(hlen_q) &&
							seen_q < MAXF) begin
							if (off == 5'd11)
								dtype_n = code;
							if (off == 5'd16)
								dlen_n = data_byte;
							if (off == 5'd31) begin
								seen_n = seen_q + 1'b1;
								if (dlen_q != 8'd0) begin
									wr_en = 1'b1;
									nz_n = nz_q + 1'b1;
									if (nz_q == '0)
										first_n = wr_ent;
								end
							end
						end
						if (pos_q >= 16'd11 && (17'(pos_q) + 17'd1) == 17'(hlen_n)) begin
							va = 1'b1;
							ra.kind = dbfp_pkg::KIND_HDR_DONE;
							ra.record_index = total_n;
							ra.date_stamp = date_n;
							ra.field_count = 9'(seen_n);
							rec_n = '0;
							phase_n = (total_n == 32'd0) ? PH_DONE : PH_FLAG;
						end else begin
							pos_n = pos_q + 1'b1;
						end
					end
					if (va && ra.kind == dbfp_pkg::KIND_ERROR)
						phase_n = PH_ERROR;
					if (va && phase_n == PH_ERROR) begin
						ra.record_index = rec_q;
						ra.field_index = 8'(cf_q);
					end
				end
				PH_FLAG: begin
					va = 1'b1;
					cf_n = '0;
					if (data_byte == dbfp_pkg::FLAG_LIVE || data_byte == dbfp_pkg::FLAG_DELETED) begin
						del_n = (data_byte == dbfp_pkg::FLAG_DELETED);
						ra.kind = dbfp_pkg::KIND_REC_START;
						ra.record_index = rec_q;
						ra.deleted = del_n;
						if (nz_q != '0) begin
							cur_n = first_q;
							cpos_n = '0;
							cf_n = first_q.idx;
							bif_n = '0;
							gath_n = '0;
							phase_n = PH_FIELD;
							rd_addr = IW'(1);
						end else begin
							rec_n = rec_q + 1'b1;
							phase_n = (rec_n == total_q) ? PH_DONE : PH_FLAG;
						end
					end else begin
						ra.kind = dbfp_pkg::KIND_ERROR;
						ra.record_index = rec_q;
						ra.error_code = dbfp_pkg::ERR_DEL_FLAG;
						phase_n = PH_ERROR;
					end
				end
				PH_FIELD: begin
					ra.record_index = rec_q;
					ra.field_index = 8'(cur_q.idx);
					ra.field_type = cur_q.ftype;
					ra.deleted = del_q;
					if (cur_q.ftype == dbfp_pkg::TYPE_CHAR && cur_q.flen == dbfp_pkg::EXT_REF_LEN) begin
						if (bif_q >= 8'd5) begin
							va = 1'b1;
							ra.kind = dbfp_pkg::KIND_EXT_REF;
							ra.ext_offset = gnew[31:0];
							ra.ext_length = gnew[47:32];
							adv = 1'b1;
						end else begin
							bif_n = bif_q + 1'b1;
							gath_n = gnew;
						end
					end else begin
						va = 1'b1;
						ra.kind = dbfp_pkg::KIND_FLD_BYTE;
						ra.field_byte = data_byte;
						if ((9'(bif_q) + 9'd1) >= 9'(cur_q.flen)) begin
							ra.last_of_field = 1'b1;
							adv = 1'b1;
						end else begin
							bif_n = bif_q + 1'b1;
						end
					end
					if (adv) begin
						if (cnext < nz_q) begin
							cur_n = rd_q;
							cpos_n = IW'(cnext);
							cf_n = rd_q.idx;
							bif_n = '0;
							gath_n = '0;
							rd_addr = IW'(cpos_q + 2'd2);
						end else begin
							rec_n = rec_q + 1'b1;
							phase_n = (rec_n == total_q) ? PH_DONE : PH_FLAG;
						end
					end
				end
				default: begin
				end
			endcase

			if (end_of_input) begin
				if (phase_n == PH_DONE) begin
					vb = 1'b1;
					rb.kind = dbfp_pkg::KIND_END;
					rb.record_index = total_n;
				end else if (phase_n != PH_ERROR) begin
					vb = 1'b1;
					rb.kind = dbfp_pkg::KIND_ERROR;
					rb.record_index = rec_n;
					rb.field_index = 8'(cf_n);
					rb.error_code = dbfp_pkg::ERR_TRUNC;
				end
				phase_n = PH_HEADER;
				pos_n = '0;
				total_n = '0;
				hlen_n = '0;
				date_n = '0;
				seen_n = '0;
				nz_n = '0;
				rec_n = '0;
				cf_n = '0;
				cpos_n = '0;
				bif_n = '0;
				gath_n = '0;
				del_n = 1'b0;
			end
		end

		res_n = 2'(va) + 2'(vb);
		res0 = va ? ra : rb;
		res1 = rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			total_q <= '0;
			hlen_q <= '0;
			date_q <= '0;
			seen_q <= '0;
			nz_q <= '0;
			rec_q <= '0;
			cf_q <= '0;
			cpos_q <= '0;
			bif_q <= '0;
			gath_q <= '0;
			del_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			total_q <= total_n;
			hlen_q <= hlen_n;
			date_q <= date_n;
			seen_q <= seen_n;
			nz_q <= nz_n;
			rec_q <= rec_n;
			cf_q <= cf_n;
			cpos_q <= cpos_n;
			bif_q <= bif_n;
			gath_q <= gath_n;
			del_q <= del_n;
		end
	end

	always_ff @(posedge clk) begin
		dtype_q <= dtype_n;
		dlen_q <= dlen_n;
		first_q <= first_n;
		cur_q <= cur_n;
		if (wr_en)
			mem[IW'(nz_q)] <= wr_ent;
		rd_q <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== design/dbfp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// dbfp_out_fifo
// Four-entry result queue; takes up to two results a cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module dbfp_out_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     push_n,
	input  wire dbfp_pkg::res_t push0,
	input  wire dbfp_pkg::res_t push1,
	output logic                room2,
	output logic                out_valid,
	input  wire logic           out_ready,
	output dbfp_pkg::res_t      head
);

	dbfp_pkg::res_t buf_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign room2 = (cnt_q <= 3'd2);
	assign head = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + push_n;
			rp_q <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			buf_q[wp_q] <= push0;
		if (push_n == 2'd2)
			buf_q[wp_q + 2'd1] <= push1;
	end

endmodule
`default_nettype wire

// ===== design/dbf_table_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// dbf_table_stream_parser_unit
// Parses a DBF table file byte stream into header, record, field, end and error items.
//
//   channel | dir | handshake             | payload
//   in      | in  | in_valid / in_ready   | data_byte, end_of_input
//   out     | out | out_valid / out_ready | kind .. field_count
//
// One byte is taken per cycle while in_ready is high; each byte gives zero, one or two result items.
// Results pass through a four-entry queue; in_ready drops when fewer than two
// slots are free, so the queue always has room for both items a byte may give.
// Asynchronous reset returns to the header phase; end of input does the same.
// ----------------------------------------------------------------------------
`default_nettype none
module dbf_table_stream_parser_unit #(
	parameter int MAX_FIELDS = dbfp_pkg::MAX_FIELDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [31:0]      record_index,
	output logic [7:0]       field_index,
	output logic [3:0]       field_type,
	output logic [7:0]       field_byte,
	output logic             last_of_field,
	output logic             deleted,
	output logic [31:0]      ext_offset,
	output logic [15:0]      ext_length,
	output logic [1:0]       error_code,
	output logic [23:0]      date_stamp,
	output logic [8:0]       field_count
);

	dbfp_pkg::res_t r0, r1, head;
	logic [1:0]     rn;
	logic           acc;

	assign acc = in_valid && in_ready;

	dbfp_parser #(.MAX_FIELDS(MAX_FIELDS)) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.res0         (r0),
		.res1         (r1),
		.res_n        (rn)
	);

	dbfp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (rn),
		.push0     (r0),
		.push1     (r1),
		.room2     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind = head.kind;
	assign record_index = head.record_index;
	assign field_index = head.field_index;
	assign field_type = head.field_type;
	assign field_byte = head.field_byte;
	assign last_of_field = head.last_of_field;
	assign deleted = head.deleted;
	assign ext_offset = head.ext_offset;
	assign ext_length = head.ext_length;
	assign error_code = head.error_code;
	assign date_stamp = head.date_stamp;
	assign field_count = head.field_count;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DBF table stream parser. Builds table files
// (well-formed, corrupted, truncated and noise), streams them byte by byte
// under several idle/stall mixes, predicts every result item and compares
// each one field by field as it leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int NFLD = dbfp_pkg::MAX_FIELDS_DEF;

	typedef enum int {PH_HDR, PH_FLAG, PH_FIELD, PH_DONE, PH_ERR} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [31:0] record_index;
	logic [7:0] field_index;
	logic [3:0] field_type;
	logic [7:0] field_byte;
	logic last_of_field;
	logic deleted;
	logic [31:0] ext_offset;
	logic [15:0] ext_length;
	logic [1:0] error_code;
	logic [23:0] date_stamp;
	logic [8:0] field_count;

	dbf_table_stream_parser_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .record_index(record_index), .field_index(field_index),
		.field_type(field_type), .field_byte(field_byte),
		.last_of_field(last_of_field), .deleted(deleted),
		.ext_offset(ext_offset), .ext_length(ext_length),
		.error_code(error_code), .date_stamp(date_stamp),
		.field_count(field_count)
	);

	always #4 clk = ~clk;

	dbfp_pkg::res_t expected_q[$];
	int fails = 0;
	int cycles = 0;
	int tx_pct = 0;
	int rx_pct = 0;

	logic [7:0] letters[12] = '{8'h43, 8'h59, 8'h4E, 8'h46, 8'h44, 8'h54,
		8'h42, 8'h49, 8'h4C, 8'h4D, 8'h47, 8'h50};

	// parser mirror
	parse_phase_t ph;
	logic [15:0] pos;
	logic [31:0] rec_total;
	logic [15:0] hdr_len;
	logic [23:0] fdate;
	logic [3:0] d_type[NFLD];
	logic [7:0] d_len[NFLD];
	int fields_n;
	logic [31:0] cur_rec;
	int cur_fld;
	int bif;
	logic [63:0] gather;
	logic del_mark;

	task automatic mirror_reset();
		ph = PH_HDR; pos = '0; rec_total = '0; hdr_len = '0; fdate = '0;
		fields_n = 0; cur_rec = '0; cur_fld = 0; bif = 0; gather = '0; del_mark = 1'b0;
	endtask

	function automatic dbfp_pkg::res_t blank(logic [2:0] k);
		dbfp_pkg::res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic raise(logic [1:0] code);
		dbfp_pkg::res_t r;
		r = blank(dbfp_pkg::KIND_ERROR);
		r.record_index = cur_rec;
		r.field_index = cur_fld[7:0];
		r.error_code = code;
		expected_q.push_back(r);
		ph = PH_ERR;
	endtask

	task automatic finish_record();
		cur_rec++;
		ph = (cur_rec == rec_total) ? PH_DONE : PH_FLAG;
	endtask

	task automatic open_from(int start);
		int i;
		i = start;
		while (i < fields_n && i < NFLD && d_len[i] == 0) i++;
		if (i >= fields_n || i >= NFLD) begin
			finish_record();
		end else begin
			cur_fld = i; bif = 0; gather = '0; ph = PH_FIELD;
		end
	endtask

	task automatic header_step(logic [7:0] b);
		int p, off, base, code;
		dbfp_pkg::res_t r;
		p = pos;
		if (p >= 1 && p <= 3) fdate = {fdate[15:0], b};
		else if (p >= 4 && p <= 7) rec_total[8*(p-4) +: 8] = b;
		else if (p == 8 || p == 9) hdr_len[8*(p-8) +: 8] = b;
		if (p == 9 && hdr_len < 12) begin
			raise(dbfp_pkg::ERR_HEADER);
			return;
		end
		if (p >= 32) begin
			off = (p - 32) & 31;
			base = p - off;
			if (base + 32 <= hdr_len) begin
				if (off == 0 && fields_n >= NFLD) begin
					raise(dbfp_pkg::ERR_HEADER);
					return;
				end
				if (fields_n < NFLD) begin
					if (off == 11) begin
						code = 12;
						for (int k = 0; k < 12; k++)
							if (code == 12 && letters[k] == b) code = k;
						if (code == 12) begin
							raise(dbfp_pkg::ERR_TYPE);
							return;
						end
						d_type[fields_n] = code[3:0];
					end else if (off == 16) begin
						d_len[fields_n] = b;
					end else if (off == 31) begin
						fields_n++;
					end
				end
			end
		end
		if (p >= 11 && p + 1 == hdr_len) begin
			r = blank(dbfp_pkg::KIND_HDR_DONE);
			r.record_index = rec_total;
			r.date_stamp = fdate;
			r.field_count = fields_n[8:0];
			expected_q.push_back(r);
			cur_rec = '0;
			ph = (rec_total == 0) ? PH_DONE : PH_FLAG;
		end else begin
			pos = pos + 16'd1;
		end
	endtask

	task automatic field_step(logic [7:0] b);
		dbfp_pkg::res_t r;
		if (d_type[cur_fld] == dbfp_pkg::TYPE_CHAR && d_len[cur_fld] == dbfp_pkg::EXT_REF_LEN) begin
			gather[8*(bif & 7) +: 8] = b;
			if (bif >= 5) begin
				r = blank(dbfp_pkg::KIND_EXT_REF);
				r.record_index = cur_rec;
				r.field_index = cur_fld[7:0];
				r.field_type = d_type[cur_fld];
				r.deleted = del_mark;
				r.ext_offset = gather[31:0];
				r.ext_length = gather[47:32];
				expected_q.push_back(r);
				open_from(cur_fld + 1);
			end else begin
				bif++;
			end
			return;
		end
		r = blank(dbfp_pkg::KIND_FLD_BYTE);
		r.record_index = cur_rec;
		r.field_index = cur_fld[7:0];
		r.field_type = d_type[cur_fld];
		r.field_byte = b;
		r.deleted = del_mark;
		if (bif + 1 >= d_len[cur_fld]) begin
			r.last_of_field = 1'b1;
			expected_q.push_back(r);
			open_from(cur_fld + 1);
		end else begin
			expected_q.push_back(r);
			bif++;
		end
	endtask

	task automatic predict_byte(logic [7:0] b, logic eoi);
		dbfp_pkg::res_t r;
		case (ph)
			PH_HDR: begin
				header_step(b);
			end
			PH_FLAG: begin
				cur_fld = 0;
				if (b == dbfp_pkg::FLAG_LIVE || b == dbfp_pkg::FLAG_DELETED) begin
					del_mark = (b == dbfp_pkg::FLAG_DELETED);
					r = blank(dbfp_pkg::KIND_REC_START);
					r.record_index = cur_rec;
					r.deleted = del_mark;
					expected_q.push_back(r);
					open_from(0);
				end else begin
					raise(dbfp_pkg::ERR_DEL_FLAG);
				end
			end
			PH_FIELD: begin
				field_step(b);
			end
			default: ;
		endcase
		if (eoi) begin
			if (ph == PH_DONE) begin
				r = blank(dbfp_pkg::KIND_END);
				r.record_index = rec_total;
				expected_q.push_back(r);
			end else if (ph != PH_ERR) begin
				raise(dbfp_pkg::ERR_TRUNC);
			end
			mirror_reset();
		end
	endtask

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		dbfp_pkg::res_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else if (arst_n) begin
			if (in_valid && in_ready) predict_byte(data_byte, end_of_input);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item, kind %0d", kind);
					fails++;
				end else begin
					e = expected_q.pop_front();
					check_field("kind", e.kind, kind);
					check_field("record_index", e.record_index, record_index);
					check_field("field_index", e.field_index, field_index);
					check_field("field_type", e.field_type, field_type);
					check_field("field_byte", e.field_byte, field_byte);
					check_field("last_of_field", e.last_of_field, last_of_field);
					check_field("deleted", e.deleted, deleted);
					check_field("ext_offset", e.ext_offset, ext_offset);
					check_field("ext_length", e.ext_length, ext_length);
					check_field("error_code", e.error_code, error_code);
					check_field("date_stamp", e.date_stamp, date_stamp);
					check_field("field_count", e.field_count, field_count);
				end
			end
		end
	end

	always @(posedge clk)
		if (arst_n) out_ready <= ($urandom_range(99) >= rx_pct);

	// file construction
	logic [7:0] file_q[$];
	logic [7:0] fld_letter[300];
	logic [7:0] fld_len[300];
	int hdr_bytes;
	int rec_bytes;
	int rand_bytes = 0;

	task automatic send(logic [7:0] b, logic eoi);
		if ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_file();
		foreach (file_q[i]) send(file_q[i], i == file_q.size() - 1);
	endtask

	task automatic rand_fields(int nf);
		for (int i = 0; i < nf; i++) begin
			if ($urandom_range(99) < 30) begin
				fld_letter[i] = letters[0];
				fld_len[i] = dbfp_pkg::EXT_REF_LEN;
			end else begin
				fld_letter[i] = letters[$urandom_range(0, 11)];
				fld_len[i] = 8'($urandom_range(0, 5));
			end
		end
	endtask

	task automatic build_file(int nf, logic [31:0] cnt, int nrec, int pad, int surplus);
		logic [15:0] hl;
		hl = 16'(32 + 32 * nf + 1 + pad);
		rec_bytes = 1;
		for (int i = 0; i < nf; i++) rec_bytes += fld_len[i];
		hdr_bytes = hl;
		file_q.delete();
		for (int i = 0; i < 4; i++) file_q.push_back(rnd_byte());
		for (int i = 0; i < 4; i++) file_q.push_back(cnt[8*i +: 8]);
		file_q.push_back(hl[7:0]);
		file_q.push_back(hl[15:8]);
		for (int i = 10; i < 32; i++) file_q.push_back(rnd_byte());
		for (int f = 0; f < nf; f++) begin
			for (int i = 0; i < 11; i++) file_q.push_back(rnd_byte());
			file_q.push_back(fld_letter[f]);
			for (int i = 0; i < 4; i++) file_q.push_back(rnd_byte());
			file_q.push_back(fld_len[f]);
			for (int i = 0; i < 15; i++) file_q.push_back(rnd_byte());
		end
		file_q.push_back(8'h0D);
		for (int i = 0; i < pad; i++) file_q.push_back(rnd_byte());
		for (int r = 0; r < nrec; r++) begin
			file_q.push_back($urandom_range(1) ? dbfp_pkg::FLAG_DELETED : dbfp_pkg::FLAG_LIVE);
			for (int i = 1; i < rec_bytes; i++) file_q.push_back(rnd_byte());
		end
		for (int i = 0; i < surplus; i++) file_q.push_back(rnd_byte());
	endtask

	function automatic logic [7:0] bad_letter();
		logic [7:0] b;
		logic hit;
		do begin
			b = rnd_byte();
			hit = 1'b0;
			foreach (letters[k]) if (letters[k] == b) hit = 1'b1;
		end while (hit);
		return b;
	endfunction

	function automatic logic [7:0] bad_flag();
		logic [7:0] b;
		do b = rnd_byte(); while (b == dbfp_pkg::FLAG_LIVE || b == dbfp_pkg::FLAG_DELETED);
		return b;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// directed tests
	task automatic test_basic();
		fld_letter[0] = letters[0]; fld_len[0] = dbfp_pkg::EXT_REF_LEN;
		fld_letter[1] = letters[2]; fld_len[1] = 3;
		fld_letter[2] = letters[11]; fld_len[2] = 0;
		fld_letter[3] = letters[9]; fld_len[3] = 1;
		build_file(4, 2, 2, 0, 0);
		send_file();
	endtask

	task automatic test_all_types();
		for (int i = 0; i < 12; i++) begin
			fld_letter[i] = letters[i];
			fld_len[i] = (i == 0) ? 8'd40 : 8'd1;
		end
		build_file(12, 1, 1, 0, 2);
		file_q[1] = 8'hFF; file_q[2] = 8'h00; file_q[3] = 8'hFF;
		send_file();
	endtask

	task automatic test_zero_records();
		rand_fields(2);
		build_file(2, 0, 0, 3, 4);
		send_file();
	endtask

	task automatic test_zero_fields();
		build_file(0, 3, 3, 0, 0);
		send_file();
	endtask

	task automatic test_short_header();
		build_file(0, 1, 0, 0, 0);
		file_q[8] = 8'($urandom_range(0, 11));
		file_q[9] = 8'h00;
		send_file();
		// header sizes 12..31: no descriptor space
		build_file(0, 0, 0, 0, 0);
		file_q[8] = 8'($urandom_range(12, 31));
		file_q[9] = 8'h00;
		file_q = file_q[0:file_q[8]-1];
		send_file();
	endtask

	task automatic test_bad_type();
		rand_fields(2);
		build_file(2, 1, 1, 0, 0);
		file_q[32 + 32 + 11] = bad_letter();
		send_file();
	endtask

	task automatic test_bad_flag();
		rand_fields(2);
		build_file(2, 3, 3, 0, 0);
		file_q[hdr_bytes + rec_bytes] = bad_flag();
		send_file();
	endtask

	task automatic test_truncated();
		rand_fields(2);
		build_file(2, 32'hFFFF_FFFF, 1, 0, 0);
		send_file();
		build_file(2, 1, 1, 0, 0);
		file_q = file_q[0:20];
		send_file();
		send(8'hA5, 1'b1);
	endtask

	task automatic rand_file();
		int nf, sel;
		nf = $urandom_range(0, 4);
		rand_fields(nf);
		build_file(nf, $urandom_range(0, 4), 0, $urandom_range(0, 30), 0);
		sel = $urandom_range(99);
		// rebuild with records now that the count is known
		build_file(nf, {24'd0, file_q[4]}, file_q[4],
			$urandom_range(0, 30), ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
		if (sel >= 72 && sel < 78 && file_q[4] != 0) begin
			file_q[hdr_bytes + rec_bytes * $urandom_range(0, file_q[4] - 1)] = bad_flag();
		end else if (sel >= 78 && sel < 84 && nf != 0) begin
			file_q[32 + 32 * $urandom_range(0, nf - 1) + 11] = bad_letter();
		end else if (sel >= 84 && sel < 88) begin
			file_q[8] = 8'($urandom_range(0, 11));
			file_q[9] = 8'h00;
		end else if (sel >= 88 && sel < 95) begin
			file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
		end else if (sel >= 95) begin
			file_q.delete();
			repeat ($urandom_range(1, 40)) file_q.push_back(rnd_byte());
		end
		rand_bytes += file_q.size();
		send_file();
	endtask

	task automatic test_random(int tx, int rx, int nbytes);
		tx_pct = tx;
		rx_pct = rx;
		nbytes += rand_bytes;
		while (rand_bytes < nbytes) rand_file();
		wait_drained();
	endtask

	initial begin
		mirror_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic();
		test_all_types();
		test_zero_records();
		test_zero_fields();
		test_short_header();
		test_bad_type();
		test_bad_flag();
		test_truncated();
		wait_drained();
		test_random(46, 0, 80);
		test_random(0, 46, 80);
		test_random(21, 21, 80);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
